// ----- rtl/wsd_pkg.sv -----
// shared constants, request and status codes, and control types for the work stealing deque
// no dependencies
package wsd_pkg;

  localparam int DEPTH       = 1024;
  localparam int HANDLE_BITS = 32;
  localparam int SLOT_W      = $clog2(DEPTH);
  localparam int IDX_W       = SLOT_W + 1;
  localparam int OCC_W       = IDX_W;
  localparam int REQ_W       = 2;
  localparam int STATUS_W    = 2;

  localparam logic [REQ_W-1:0] REQ_PUSH  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_POP   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_STEAL = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef logic [IDX_W-1:0]       idx_t;
  typedef logic [SLOT_W-1:0]      slot_t;
  typedef logic [HANDLE_BITS-1:0] handle_t;

  typedef struct packed {
    logic load;
    logic capture;
  } wsd_cmd_t;

endpackage

// ----- rtl/work_stealing_deque.sv -----
// work stealing deque top level: one request in, one result out
// a request transfer is followed by the S_READ state, then the result is held in S_OUT (slot store read is registered)
// the one-request sequencer takes a new request only after the previous result transfer completes
// reset: synchronous active-low rst_n empties the deque; slot contents are left as they are
// depends on wsd_pkg, wsd_ctrl, wsd_dp, wsd_ram
module work_stealing_deque (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [wsd_pkg::REQ_W-1:0]     in_req_type,
  input  logic [31:0]                   in_task_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [31:0]                   out_task_out,
  output logic [wsd_pkg::STATUS_W-1:0]  out_status,
  output logic [wsd_pkg::OCC_W-1:0]     out_occupancy
);
  import wsd_pkg::*;

  wsd_cmd_t cmd;

  wsd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  wsd_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .req_type  (in_req_type),
    .task_in   (in_task_in),
    .task_out  (out_task_out),
    .status    (out_status),
    .occupancy (out_occupancy)
  );

endmodule

// ----- rtl/wsd_ram.sv -----
// generic single write port, single read port ram with registered read data
// no dependencies
module wsd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/wsd_ctrl.sv -----
// request sequencer: accept, slot read, result hold
// depends on wsd_pkg
module wsd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output wsd_pkg::wsd_cmd_t cmd
);
  import wsd_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_READ;
      end
      S_READ: state_nxt = S_OUT;
      S_OUT: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready    = (state_r == S_IDLE);
  assign out_valid   = (state_r == S_OUT);
  assign cmd.load    = in_ready && in_valid;
  assign cmd.capture = (state_r == S_READ);

endmodule

// ----- rtl/wsd_dp.sv -----
// deque datapath: top and bottom indices, slot store, result registers
// depends on wsd_pkg and wsd_ram
module wsd_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  wsd_pkg::wsd_cmd_t             cmd,
  input  logic [wsd_pkg::REQ_W-1:0]     req_type,
  input  logic [31:0]                   task_in,
  output logic [31:0]                   task_out,
  output logic [wsd_pkg::STATUS_W-1:0]  status,
  output logic [wsd_pkg::OCC_W-1:0]     occupancy
);
  import wsd_pkg::*;

  idx_t                top_r, top_nxt;
  idx_t                bottom_r, bottom_nxt;
  logic                take_r, take_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [31:0]         task_out_r;
  logic [OCC_W-1:0]    occ_r;

  idx_t    held;
  idx_t    bot_dec;
  idx_t    top_inc;
  logic    empty;
  logic    full;
  logic    we;
  slot_t   raddr;
  handle_t rdata;

  assign held    = bottom_r - top_r;
  assign bot_dec = bottom_r - idx_t'(1);
  assign top_inc = top_r + idx_t'(1);
  assign empty   = (held == '0);
  assign full    = held[IDX_W-1];

  always_comb begin
    top_nxt    = top_r;
    bottom_nxt = bottom_r;
    take_nxt   = 1'b0;
    status_nxt = ST_DONE;
    we         = 1'b0;
    raddr      = top_r[SLOT_W-1:0];
    unique case (req_type)
      REQ_PUSH: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          we         = cmd.load;
          bottom_nxt = bottom_r + idx_t'(1);
        end
      end
      REQ_POP: begin
        raddr = bot_dec[SLOT_W-1:0];
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          take_nxt = 1'b1;
          if (held == idx_t'(1)) begin
            top_nxt    = top_inc;
            bottom_nxt = top_inc;
          end else begin
            bottom_nxt = bot_dec;
          end
        end
      end
      REQ_STEAL: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          take_nxt = 1'b1;
          top_nxt  = top_inc;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r    <= '0;
      bottom_r <= '0;
    end else if (cmd.load) begin
      top_r    <= top_nxt;
      bottom_r <= bottom_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      take_r   <= take_nxt;
      status_r <= status_nxt;
    end
    if (cmd.capture) begin
      task_out_r <= take_r ? 32'(rdata) : '0;
      occ_r      <= OCC_W'(bottom_r - top_r);
    end
  end

  wsd_ram #(
    .WIDTH (HANDLE_BITS),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (we),
    .waddr (bottom_r[SLOT_W-1:0]),
    .wdata (task_in[HANDLE_BITS-1:0]),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign task_out  = task_out_r;
  assign status    = status_r;
  assign occupancy = occ_r;

endmodule

// ----- rtl/wsd_checker.sv -----
// port-level checks for the work stealing deque, bound to the top level
// depends on wsd_pkg and work_stealing_deque
module wsd_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [31:0]                   out_task_out,
  input logic [wsd_pkg::STATUS_W-1:0]  out_status,
  input logic [wsd_pkg::OCC_W-1:0]     out_occupancy
);
  import wsd_pkg::*;

  // one request in flight at a time
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another is in flight");

  // nothing taken means a zero handle
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_DONE |-> out_task_out == '0)
    else $error("nonzero handle on empty or full status");

  // full rejection leaves the deque full
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |-> out_occupancy == OCC_W'(DEPTH))
    else $error("full status with occupancy below depth");

  // empty status leaves the deque empty
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_EMPTY |-> out_occupancy == '0)
    else $error("empty status with nonzero occupancy");

  // stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_task_out) && $stable(out_occupancy))
    else $error("result changed while stalled");

endmodule

bind work_stealing_deque wsd_checker u_wsd_checker (.*);

// ----- sim/work_stealing_deque_tb.sv -----
// self-checking testbench for work_stealing_deque: directed corner cases, random request mixes,
// a deep grow and drain, and output back-pressure, checked against an in-bench predictor
// depends on wsd_pkg and the work_stealing_deque rtl
module work_stealing_deque_tb;
  import wsd_pkg::*;

  localparam logic [REQ_W-1:0] REQ_NONE = 2'd3;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct {
    handle_t              task_out;
    logic [STATUS_W-1:0]  status;
    logic [OCC_W-1:0]     occupancy;
  } deque_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [REQ_W-1:0]     in_req_type = REQ_PUSH;
  logic [31:0]          in_task_in = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [31:0]          out_task_out;
  logic [STATUS_W-1:0]  out_status;
  logic [OCC_W-1:0]     out_occupancy;

  handle_t       model_slots [DEPTH];
  idx_t          model_top = '0;
  idx_t          model_bottom = '0;
  deque_result_t pending_results [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_left = 0;
  int error_count = 0;
  int cycle_count = 0;

  work_stealing_deque i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_req_type   (in_req_type),
    .in_task_in    (in_task_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_task_out  (out_task_out),
    .out_status    (out_status),
    .out_occupancy (out_occupancy)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results pending", $time, pending_results.size());
      $display("simulation failed");
      $finish;
    end
  end

  function automatic idx_t model_held();
    return idx_t'(model_bottom - model_top);
  endfunction

  function automatic void predict_request(logic [REQ_W-1:0] req, handle_t data);
    deque_result_t res;
    idx_t          held;
    held = model_held();
    res.task_out = '0;
    res.status = ST_DONE;
    case (req)
      REQ_PUSH: begin
        if (held >= idx_t'(DEPTH)) begin
          res.status = ST_FULL;
        end else begin
          model_slots[slot_t'(model_bottom)] = data;
          model_bottom = model_bottom + 1'b1;
        end
      end
      REQ_POP: begin
        if (held == '0) begin
          res.status = ST_EMPTY;
        end else begin
          res.task_out = model_slots[slot_t'(model_bottom - 1'b1)];
          if (held == idx_t'(1)) begin
            model_top = model_top + 1'b1;
            model_bottom = model_top;
          end else begin
            model_bottom = model_bottom - 1'b1;
          end
        end
      end
      REQ_STEAL: begin
        if (held == '0) begin
          res.status = ST_EMPTY;
        end else begin
          res.task_out = model_slots[slot_t'(model_top)];
          model_top = model_top + 1'b1;
        end
      end
      default: begin
      end
    endcase
    res.occupancy = OCC_W'(model_held());
    pending_results.push_back(res);
  endfunction

  // input transfer monitor
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) predict_request(in_req_type, in_task_in);
  end

  // result receiver and checker
  always @(posedge clk) begin : result_check
    deque_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result task_out=%h status=%0d occupancy=%0d",
                 $time, out_task_out, out_status, out_occupancy);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_task_out !== want.task_out) begin
          $display("%0t: task_out expected %h actual %h", $time, want.task_out, out_task_out);
          error_count++;
        end
        if (out_status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
          error_count++;
        end
        if (out_occupancy !== want.occupancy) begin
          $display("%0t: occupancy expected %0d actual %0d",
                   $time, want.occupancy, out_occupancy);
          error_count++;
        end
      end
    end
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_request(logic [REQ_W-1:0] req, logic [31:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= req;
    in_task_in <= data;
    do @(posedge clk); while (!in_ready);
  endtask

  // sender pauses until every result has been taken
  task automatic wait_drained();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed_cases();
    send_request(REQ_POP, 32'h1234_5678);
    send_request(REQ_STEAL, 32'hffff_ffff);
    send_request(REQ_NONE, 32'hffff_ffff);
    send_request(REQ_PUSH, 32'h0000_0000);
    send_request(REQ_PUSH, 32'hffff_ffff);
    send_request(REQ_PUSH, 32'ha5a5_5a5a);
    send_request(REQ_NONE, 32'h0000_0000);
    send_request(REQ_POP, 32'h0);
    send_request(REQ_STEAL, 32'h0);
    // pop of the last entry empties the deque
    send_request(REQ_POP, 32'hffff_ffff);
    send_request(REQ_POP, 32'h0);
    send_request(REQ_PUSH, 32'h8000_0001);
    send_request(REQ_PUSH, 32'h7fff_fffe);
    send_request(REQ_STEAL, 32'h0);
    send_request(REQ_STEAL, 32'h0);
    send_request(REQ_STEAL, 32'h0);
    send_request(REQ_PUSH, 32'hdead_beef);
    send_request(REQ_POP, 32'h0);
    send_request(REQ_NONE, 32'h5555_aaaa);
    wait_drained();
  endtask

  task automatic test_random_mix(int count);
    int pick;
    logic [REQ_W-1:0] req;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 5) req = REQ_NONE;
      else if (pick < 52) req = REQ_PUSH;
      else if (pick < 76) req = REQ_POP;
      else req = REQ_STEAL;
      send_request(req, $urandom());
    end
  endtask

  // receiver holds off while the sender keeps offering, so input stalls
  task automatic test_receiver_hold();
    stall_left = 400;
    for (int n = 0; n < 40; n++) send_request(REQ_PUSH, $urandom());
    for (int n = 0; n < 20; n++) send_request($urandom_range(1) ? REQ_POP : REQ_STEAL, $urandom());
    wait_drained();
  endtask

  // grow the deque deep, then take everything and run past empty
  task automatic test_grow_and_drain();
    int takes;
    wait_drained();
    takes = int'(model_held()) + 71 + 2;
    for (int n = 0; n < 70; n++) send_request(REQ_PUSH, $urandom());
    send_request(REQ_PUSH, 32'hffff_ffff);
    send_request(REQ_NONE, $urandom());
    for (int n = 0; n < takes; n++) begin
      send_request($urandom_range(1) ? REQ_POP : REQ_STEAL, $urandom());
    end
    wait_drained();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 36;
    recv_idle_pct = 50;
    test_directed_cases();
    test_random_mix(240);
    test_receiver_hold();
    send_idle_pct = 50;
    recv_idle_pct = 36;
    test_random_mix(240);
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_mix(240);
    test_grow_and_drain();
    repeat (10) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t: results expected %0d actual 0", $time, pending_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
